// File: src/bra_pkg.sv
// shared types and constants of the bitmap run allocator
// no dependencies; imported by bra_ctrl, bra_dp and bitmap_run_allocator_core
package bra_pkg;

  // default pool size in slots
  localparam int BRA_POOL_SLOTS = 256;

  // configuration register indexes
  localparam logic [1:0] CFG_POOL_BASE    = 2'd0;
  localparam logic [1:0] CFG_POOL_COUNT   = 2'd1;
  localparam logic [1:0] CFG_FROM_LOW_END = 2'd2;

  // request command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // error codes carried in the result
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_RUN  = 2'd1,
    ERR_UNUSED  = 2'd2,
    ERR_OUTSIDE = 2'd3
  } err_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the request fields
    logic start;     // clear walk counters before a scan, check or write
    logic init_wr;   // clearing pass: zero one map entry
    logic go;        // walk the map: scan for allocate, check for free
    logic wr_go;     // write one slot of the chosen run
    logic cnt_upd;   // update the used and peak counts
    logic rsp_load;  // load the result register
    err_t rsp_err;   // error code to load with the result
  } bra_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic init_last;
    logic is_free;
    logic len_zero;
    logic alloc_bad;
    logic outside;
    logic hit;
    logic miss;
    logic chk_bad;
    logic chk_done;
    logic wr_last;
  } bra_sts_t;

endpackage

// File: src/bitmap_run_allocator_core.sv
// Bitmap run allocator. A request on the in_ stream either allocates a run of
// free slots (first fit, scanning up from the lowest or down from the highest
// slot, inside an optional address window) or frees a run of used slots. Each
// request gives exactly one result on the out_ stream with the success flag,
// the run address, an error code and the current and peak used counts.
// Registers pool_base, pool_count and from_low_end are written on the cfg_
// port; the user must write them only while the block is idle, which the
// block itself does not enforce.
// Flow: a request is captured and decoded, then an allocate walks the slot
// map one slot per cycle through the single read port of the map memory,
// and a free checks its run one slot per cycle; a successful command then
// writes its run one slot per cycle through the write port. The result
// register is loaded last; an early failure goes straight to it.
// After reset a clearing pass zeroes all POOL_SLOTS map entries, during which
// in_tready stays low. A result waits in its register while out_tready is
// low; the next request is accepted meanwhile but its own result is held
// back until the waiting one is taken.
// depends on bra_pkg, bra_ctrl and bra_dp
module bitmap_run_allocator_core import bra_pkg::*; #(
  parameter int POOL_SLOTS = BRA_POOL_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // address[15:0], run_length[24:16],
                                  // window_low[41:25], window_high[58:42]
  input  logic        in_tuser,   // command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // success[0], result_address[16:1],
                                  // error_code[18:17], current_used[27:19],
                                  // peak_used[36:28]
);

  bra_cmd_t    cmd;
  bra_sts_t    sts;
  logic        rsp_success;
  logic [15:0] rsp_result_address;
  logic [1:0]  rsp_error_code;
  logic [8:0]  rsp_current_used;
  logic [8:0]  rsp_peak_used;

  // controller
  bra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  bra_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .req_command        (in_tuser),
    .req_address        (in_tdata[15:0]),
    .req_run_length     (in_tdata[24:16]),
    .req_window_low     (in_tdata[41:25]),
    .req_window_high    (in_tdata[58:42]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rsp_success        (rsp_success),
    .rsp_result_address (rsp_result_address),
    .rsp_error_code     (rsp_error_code),
    .rsp_current_used   (rsp_current_used),
    .rsp_peak_used      (rsp_peak_used)
  );

  // result packing
  assign out_tdata = {3'd0, rsp_peak_used, rsp_current_used, rsp_error_code,
                      rsp_result_address, rsp_success};

endmodule

// File: src/bra_ctrl.sv
// controller state machine of the bitmap run allocator
// depends on bra_pkg; drives bra_dp through bra_cmd_t and reads bra_sts_t
module bra_ctrl import bra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  bra_sts_t sts_i,
  output bra_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_CHECK  = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  err_t   err_r, err_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd_o         = '0;
    cmd_o.rsp_err = err_r;
    case (state_r)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.start = 1'b1;
        if (!sts_i.is_free) begin
          if (sts_i.alloc_bad) begin
            err_nxt   = ERR_NO_RUN;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else if (sts_i.len_zero) begin
          err_nxt   = ERR_NONE;
          state_nxt = ST_RESP;
        end else if (sts_i.outside) begin
          err_nxt   = ERR_OUTSIDE;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_SCAN: begin
        cmd_o.go = 1'b1;
        if (sts_i.hit) begin
          state_nxt = ST_WRITE;
        end else if (sts_i.miss) begin
          err_nxt   = ERR_NO_RUN;
          state_nxt = ST_RESP;
        end
      end
      ST_CHECK: begin
        cmd_o.go = 1'b1;
        if (sts_i.chk_bad) begin
          err_nxt   = ERR_UNUSED;
          state_nxt = ST_RESP;
        end else if (sts_i.chk_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr_go = 1'b1;
        if (sts_i.wr_last) begin
          cmd_o.cnt_upd = 1'b1;
          err_nxt       = ERR_NONE;
          state_nxt     = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          cmd_o.rsp_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/bra_dp.sv
// datapath of the bitmap run allocator: config, request, slot map, counters
// depends on bra_pkg; commanded by bra_ctrl
module bra_dp import bra_pkg::*; #(
  parameter int POOL_SLOTS = BRA_POOL_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               req_command,
  input  logic [15:0]        req_address,
  input  logic [8:0]         req_run_length,
  input  logic signed [16:0] req_window_low,
  input  logic signed [16:0] req_window_high,
  input  bra_cmd_t           cmd_i,
  output bra_sts_t           sts_o,
  output logic               rsp_success,
  output logic [15:0]        rsp_result_address,
  output logic [1:0]         rsp_error_code,
  output logic [8:0]         rsp_current_used,
  output logic [8:0]         rsp_peak_used
);

  localparam int IW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW  = $clog2(POOL_SLOTS + 1);
  localparam int LIM = (CW > 9) ? CW : 9;
  localparam int LW  = ((IW > 9) ? IW : 9) + 1;
  localparam int SW  = LIM + 1;

  // configuration
  logic [15:0] base_r;
  logic [8:0]  count_r;
  logic        low_end_r;

  // captured request
  logic               cmd_r;
  logic [15:0]        addr_r;
  logic [8:0]         len_r;
  logic signed [16:0] wl_r;
  logic signed [16:0] wh_r;

  // walk state
  logic [LIM-1:0] c_r;
  logic           ev_vld_r;
  logic           ev_last_r;
  logic [IW-1:0]  ev_idx_r;
  logic [8:0]     run_r;
  logic [IW-1:0]  first_r;
  logic [8:0]     wcnt_r;
  logic           rd_r;

  // counts
  logic [CW-1:0] used_r;
  logic [CW-1:0] peak_r;

  // result register
  logic        o_ok_r;
  logic [15:0] o_addr_r;
  err_t        o_err_r;
  logic [8:0]  o_cur_r;
  logic [8:0]  o_peak_r;

  // slot map
  logic mem [POOL_SLOTS];

  logic [LIM-1:0] cnt_ext;
  logic [CW-1:0]  n;
  logic [15:0]    s;
  logic [16:0]    s_end;
  logic [LIM-1:0] lim;
  logic           issue;
  logic [IW-1:0]  raddr;
  logic [15:0]    ev_addr;
  logic           blocked;
  logic           hit;
  logic [IW-1:0]  hit_first;
  logic [IW-1:0]  wptr;
  logic           we;
  logic [IW-1:0]  waddr;
  logic           wdata;
  logic [SW-1:0]  used_add;
  logic [SW-1:0]  used_sub;

  // effective pool size
  assign cnt_ext = LIM'(count_r);
  assign n = (cnt_ext > LIM'(POOL_SLOTS)) ? CW'(POOL_SLOTS) : CW'(cnt_ext);

  // free run start slot and its end against the pool
  assign s     = addr_r - base_r;
  assign s_end = {1'b0, s} + 17'(len_r);

  // walk limit and read address
  assign lim   = (cmd_r == CMD_FREE) ? LIM'(len_r) : LIM'(n);
  assign issue = cmd_i.go && (c_r < lim);
  always_comb begin
    if (cmd_r == CMD_FREE) raddr = IW'(LW'(s[IW-1:0]) + LW'(c_r));
    else if (low_end_r)    raddr = IW'(c_r);
    else                   raddr = IW'(LIM'(n) - LIM'(1) - c_r);
  end

  // scan evaluation of one slot
  assign ev_addr = base_r + 16'(ev_idx_r);
  assign blocked = (!wl_r[16] && (ev_addr < wl_r[15:0])) ||
                   (!wh_r[16] && (ev_addr >= wh_r[15:0])) || rd_r;
  assign hit     = ev_vld_r && !blocked && ((10'(run_r) + 10'd1) == 10'(len_r));
  assign hit_first = low_end_r ? IW'(LW'(ev_idx_r) + LW'(1) - LW'(len_r)) : ev_idx_r;

  // map write port
  assign wptr  = IW'(LW'(first_r) + LW'(wcnt_r));
  assign we    = cmd_i.init_wr || cmd_i.wr_go;
  assign waddr = cmd_i.init_wr ? IW'(c_r) : wptr;
  assign wdata = cmd_i.init_wr ? 1'b0 : (cmd_r == CMD_ALLOC);

  assign used_add = SW'(used_r) + SW'(len_r);
  assign used_sub = SW'(used_r) - SW'(len_r);

  // status
  always_comb begin
    sts_o           = '0;
    sts_o.init_last = (c_r == LIM'(POOL_SLOTS - 1));
    sts_o.is_free   = (cmd_r == CMD_FREE);
    sts_o.len_zero  = (len_r == 9'd0);
    sts_o.alloc_bad = (len_r == 9'd0) || (LIM'(len_r) > LIM'(n));
    sts_o.outside   = (s_end > 17'(n));
    sts_o.hit       = hit;
    sts_o.miss      = ev_vld_r && ev_last_r && !hit;
    sts_o.chk_bad   = ev_vld_r && !rd_r;
    sts_o.chk_done  = ev_vld_r && ev_last_r && rd_r;
    sts_o.wr_last   = ((10'(wcnt_r) + 10'd1) == 10'(len_r));
  end

  // slot map memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= 16'd0;
      count_r   <= 9'd256;
      low_end_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POOL_BASE:    base_r    <= cfg_wdata;
        CFG_POOL_COUNT:   count_r   <= cfg_wdata[8:0];
        CFG_FROM_LOW_END: low_end_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r  <= req_command;
      addr_r <= req_address;
      len_r  <= req_run_length;
      wl_r   <= req_window_low;
      wh_r   <= req_window_high;
    end
  end

  // walk counters and evaluation stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r      <= '0;
      ev_vld_r <= 1'b0;
      wcnt_r   <= 9'd0;
    end else if (cmd_i.start) begin
      c_r      <= '0;
      ev_vld_r <= 1'b0;
      wcnt_r   <= 9'd0;
    end else begin
      if (cmd_i.init_wr || issue) c_r <= c_r + LIM'(1);
      ev_vld_r <= issue;
      if (cmd_i.wr_go) wcnt_r <= wcnt_r + 9'd1;
    end
  end

  // evaluation payload, run length and run start
  always_ff @(posedge clk) begin
    ev_idx_r  <= raddr;
    ev_last_r <= ((c_r + LIM'(1)) == lim);
    if (cmd_i.start) begin
      run_r   <= 9'd0;
      first_r <= s[IW-1:0];
    end else if (cmd_i.go && ev_vld_r && (cmd_r == CMD_ALLOC)) begin
      run_r <= blocked ? 9'd0 : run_r + 9'd1;
      if (hit) first_r <= hit_first;
    end
  end

  // used and peak counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      peak_r <= '0;
    end else if (cmd_i.cnt_upd) begin
      if (cmd_r == CMD_ALLOC) begin
        used_r <= CW'(used_add);
        if (used_add > SW'(peak_r)) peak_r <= CW'(used_add);
      end else begin
        used_r <= CW'(used_sub);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.rsp_load) begin
      o_ok_r   <= (cmd_i.rsp_err == ERR_NONE);
      o_addr_r <= ((cmd_i.rsp_err == ERR_NONE) && (cmd_r == CMD_ALLOC)) ?
                  (base_r + 16'(first_r)) : 16'd0;
      o_err_r  <= cmd_i.rsp_err;
      o_cur_r  <= 9'(used_r);
      o_peak_r <= 9'(peak_r);
    end
  end

  assign rsp_success        = o_ok_r;
  assign rsp_result_address = o_addr_r;
  assign rsp_error_code     = o_err_r;
  assign rsp_current_used   = o_cur_r;
  assign rsp_peak_used      = o_peak_r;

endmodule
